// ----- rtl/core/tlik_pkg.sv -----
// Shared types, constants and the CORDIC angle table for the two-link leg IK core.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package tlik_pkg;

  localparam int COORD_BITS = 16;
  localparam int LINK_W     = 15;
  localparam int DEG_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER    = 2'd2;

  // leg corners
  localparam logic [1:0] CORNER_LB = 2'd0;
  localparam logic [1:0] CORNER_RB = 2'd1;
  localparam logic [1:0] CORNER_LF = 2'd2;
  localparam logic [1:0] CORNER_RF = 2'd3;

  // atan2 unit geometry
  localparam int AT_IN_W      = 32;
  localparam int XW           = 45;
  localparam int MW           = 41;
  localparam int ZW           = 26;
  localparam int NORM_TGT     = 40;
  localparam int NORM_STAGES  = 6;
  localparam int CORDIC_STEPS = 20;
  localparam int ATAN_LAT     = 1 + NORM_STAGES + CORDIC_STEPS;

  localparam int DSQ_STEPS = 16;
  localparam int DIV_STEPS = 30;
  localparam int ASQ_STEPS = 31;

  // start-to-strobe latency in cycles
  localparam int PIPE_LAT = 3 + DSQ_STEPS + 2 + DIV_STEPS + 3 + ASQ_STEPS + ATAN_LAT + 2;

  localparam logic signed [ZW-1:0] DEG90_Q16  = 26'sd5898240;
  localparam logic signed [ZW-1:0] DEG180_Q16 = 26'sd11796480;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] target_height;
    logic signed [COORD_BITS-1:0] reach;
  } tlik_in_t;

  typedef struct packed {
    logic [DEG_W-1:0] hip_angle;
    logic [DEG_W-1:0] knee_angle;
  } tlik_out_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117304;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/two_link_leg_inverse_kinematics_core.sv -----
// Top level of the two-link leg inverse kinematics core: distance, law-of-cosines
// arguments, acos/atan2 and angle mapping. Depends on tlik_pkg and tlik_atan2.
//
// Fully pipelined: one target is taken per clock (busy stays low) and each result
// appears as a one-cycle result_valid strobe at the end of the pipeline.
// The pipeline depth is set by the bit-serial stages: a 16-step square root of the
// distance, two 30-step restoring dividers for the cosine arguments, two 31-step
// square roots for the sines, and three 27-stage CORDIC atan2 units. The results cannot
// be held off; the receiver must take each strobe as it comes. Configuration may
// be written at any time the pipeline holds no target.
`default_nettype none

module two_link_leg_inverse_kinematics_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire tlik_pkg::tlik_in_t                target,
  output logic                                   result_valid,
  output tlik_pkg::tlik_out_t                    result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tlik_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tlik_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tlik_pkg::*;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] h;
    logic signed [COORD_BITS-1:0] r;
    logic signed [33:0]           kn;
    logic signed [33:0]           hn;
    logic                         far;
    logic                         d2z;
  } front_t;

  typedef struct packed {
    logic kneg;
    logic kbig;
    logic hneg;
    logic hbig;
  } dflag_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] h;
    logic signed [COORD_BITS-1:0] r;
    logic signed [31:0]           a_h;
    logic signed [31:0]           a_k;
  } acarry_t;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic [60:0]        ONE_Q60 = 61'(1) << 60;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration
  logic [LINK_W-1:0] upper_len, lower_len;
  logic [1:0]        corner;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= 15'd2560;
      lower_len <= 15'd2560;
      corner    <= CORNER_LB;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_UPPER_LEN: upper_len <= cfg_data[LINK_W-1:0];
        REG_LOWER_LEN: lower_len <= cfg_data[LINK_W-1:0];
        REG_CORNER:    corner    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [LINK_W-1:0] u_eff, l_eff;
  assign u_eff = (upper_len == '0) ? LINK_W'(1) : upper_len;
  assign l_eff = (lower_len == '0) ? LINK_W'(1) : lower_len;

  // link-derived constants, refreshed every cycle
  logic [29:0] u2, l2;
  logic [30:0] ul2;
  logic [31:0] reach_max;
  logic [15:0] ul_sum;
  assign ul_sum = {1'b0, u_eff} + {1'b0, l_eff};

  always_ff @(posedge clk) begin
    u2        <= 30'(u_eff) * 30'(u_eff);
    l2        <= 30'(l_eff) * 30'(l_eff);
    ul2       <= {30'(u_eff) * 30'(l_eff), 1'b0};
    reach_max <= 32'(ul_sum) * 32'(ul_sum);
  end

  // s1: input register
  logic                         v1;
  logic signed [COORD_BITS-1:0] h1, r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    h1 <= target.target_height;
    r1 <= target.reach;
  end

  // s2: squares
  logic                         v2;
  logic signed [COORD_BITS-1:0] h2, r2;
  logic [31:0]                  hh2, rr2;
  logic [COORD_BITS-1:0]        h1_mag, r1_mag;

  assign h1_mag = h1[COORD_BITS-1] ? COORD_BITS'(-h1) : COORD_BITS'(h1);
  assign r1_mag = r1[COORD_BITS-1] ? COORD_BITS'(-r1) : COORD_BITS'(r1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    h2  <= h1;
    r2  <= r1;
    hh2 <= 32'(h1_mag) * 32'(h1_mag);
    rr2 <= 32'(r1_mag) * 32'(r1_mag);
  end

  // s3: distance squared and numerators; feeds the distance square root
  logic        dsq_v   [0:DSQ_STEPS];
  front_t      dsq_c   [0:DSQ_STEPS];
  logic [31:0] dsq_n   [0:DSQ_STEPS];
  logic [32:0] dsq_res [0:DSQ_STEPS];
  logic [31:0] d2;

  assign d2 = hh2 + rr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      dsq_v[0] <= 1'b0;
    end else begin
      dsq_v[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dsq_c[0].h   <= h2;
    dsq_c[0].r   <= r2;
    dsq_c[0].kn  <= {4'b0, u2} + {4'b0, l2} - {2'b0, d2};
    dsq_c[0].hn  <= {4'b0, u2} + {2'b0, d2} - {4'b0, l2};
    dsq_c[0].far <= d2 >= reach_max;
    dsq_c[0].d2z <= d2 == '0;
    dsq_n[0]     <= d2;
    dsq_res[0]   <= '0;
  end

  for (genvar i = 0; i < DSQ_STEPS; i++) begin : g_dsq
    localparam logic [32:0] BIT = 33'(1) << (30 - 2 * i);
    logic [32:0] trial;
    assign trial = dsq_res[i] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        dsq_v[i+1] <= 1'b0;
      end else begin
        dsq_v[i+1] <= dsq_v[i];
      end
    end

    always_ff @(posedge clk) begin
      dsq_c[i+1] <= dsq_c[i];
      if ({1'b0, dsq_n[i]} >= trial) begin
        dsq_n[i+1]   <= 32'({1'b0, dsq_n[i]} - trial);
        dsq_res[i+1] <= (dsq_res[i] >> 1) + BIT;
      end else begin
        dsq_n[i+1]   <= dsq_n[i];
        dsq_res[i+1] <= dsq_res[i] >> 1;
      end
    end
  end

  // hip denominator 2*U*d
  logic        mv;
  front_t      mc;
  logic [31:0] hden;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else begin
      mv <= dsq_v[DSQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    mc   <= dsq_c[DSQ_STEPS];
    hden <= {31'(u_eff) * 31'(dsq_res[DSQ_STEPS][15:0]), 1'b0};
  end

  // divider setup: magnitude, sign, and whether the quotient reaches one
  logic        dv    [0:DIV_STEPS];
  front_t      dc    [0:DIV_STEPS];
  dflag_t      df    [0:DIV_STEPS];
  logic [32:0] krem  [0:DIV_STEPS];
  logic [32:0] hrem  [0:DIV_STEPS];
  logic [32:0] hdenp [0:DIV_STEPS];
  logic [29:0] kq    [0:DIV_STEPS];
  logic [29:0] hq    [0:DIV_STEPS];

  logic signed [33:0] kn_neg, hn_neg;
  logic [32:0]        kabs, habs, kden;

  always_comb begin
    kn_neg = -mc.kn;
    hn_neg = -mc.hn;
    kabs   = mc.kn[33] ? kn_neg[32:0] : mc.kn[32:0];
    habs   = mc.hn[33] ? hn_neg[32:0] : mc.hn[32:0];
    kden   = {2'b0, ul2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= mv;
    end
  end

  always_ff @(posedge clk) begin
    dc[0]      <= mc;
    df[0].kneg <= mc.kn[33];
    df[0].kbig <= kabs >= kden;
    df[0].hneg <= mc.hn[33];
    df[0].hbig <= habs >= {1'b0, hden};
    krem[0]    <= kabs;
    hrem[0]    <= habs;
    hdenp[0]   <= {1'b0, hden};
    kq[0]      <= '0;
    hq[0]      <= '0;
  end

  // restoring dividers, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [33:0] k2, h2s;
    assign k2  = {krem[j], 1'b0};
    assign h2s = {hrem[j], 1'b0};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else begin
        dv[j+1] <= dv[j];
      end
    end

    always_ff @(posedge clk) begin
      dc[j+1]    <= dc[j];
      df[j+1]    <= df[j];
      hdenp[j+1] <= hdenp[j];
      if (k2 >= {1'b0, kden}) begin
        krem[j+1] <= 33'(k2 - {1'b0, kden});
        kq[j+1]   <= {kq[j][28:0], 1'b1};
      end else begin
        krem[j+1] <= k2[32:0];
        kq[j+1]   <= {kq[j][28:0], 1'b0};
      end
      if (h2s >= {1'b0, hdenp[j]}) begin
        hrem[j+1] <= 33'(h2s - {1'b0, hdenp[j]});
        hq[j+1]   <= {hq[j][28:0], 1'b1};
      end else begin
        hrem[j+1] <= h2s[32:0];
        hq[j+1]   <= {hq[j][28:0], 1'b0};
      end
    end
  end

  // clamped Q30 cosine arguments
  logic               av;
  logic signed [31:0] a_h, a_k;
  logic signed [COORD_BITS-1:0] ah, ar;
  logic signed [31:0] kqs, hqs;
  front_t             fc;
  dflag_t             ff;

  always_comb begin
    fc  = dc[DIV_STEPS];
    ff  = df[DIV_STEPS];
    kqs = {2'b0, kq[DIV_STEPS]};
    hqs = {2'b0, hq[DIV_STEPS]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
    end else begin
      av <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    ah <= fc.h;
    ar <= fc.r;
    if (fc.far) begin
      a_k <= -ONE_Q30;
    end else if (ff.kbig) begin
      a_k <= ff.kneg ? -ONE_Q30 : ONE_Q30;
    end else begin
      a_k <= ff.kneg ? -kqs : kqs;
    end
    if (fc.far || fc.d2z) begin
      a_h <= ONE_Q30;
    end else if (ff.hbig) begin
      a_h <= ff.hneg ? -ONE_Q30 : ONE_Q30;
    end else begin
      a_h <= ff.hneg ? -hqs : hqs;
    end
  end

  // a*a
  logic        qv;
  acarry_t     qc;
  logic [61:0] asq_h, asq_k;
  logic [30:0] ah_mag, ak_mag;
  logic signed [31:0] ah_neg, ak_neg;

  always_comb begin
    ah_neg = -a_h;
    ak_neg = -a_k;
    ah_mag = a_h[31] ? ah_neg[30:0] : a_h[30:0];
    ak_mag = a_k[31] ? ak_neg[30:0] : a_k[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
    end else begin
      qv <= av;
    end
  end

  always_ff @(posedge clk) begin
    qc.h   <= ah;
    qc.r   <= ar;
    qc.a_h <= a_h;
    qc.a_k <= a_k;
    asq_h  <= 62'(ah_mag) * 62'(ah_mag);
    asq_k  <= 62'(ak_mag) * 62'(ak_mag);
  end

  // 1 - a^2 in Q60, then square root for the sine
  logic        sv    [0:ASQ_STEPS];
  acarry_t     sc    [0:ASQ_STEPS];
  logic [61:0] sn_h  [0:ASQ_STEPS];
  logic [61:0] sn_k  [0:ASQ_STEPS];
  logic [61:0] sr_h  [0:ASQ_STEPS];
  logic [61:0] sr_k  [0:ASQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= qv;
    end
  end

  always_ff @(posedge clk) begin
    sc[0]   <= qc;
    sn_h[0] <= {1'b0, ONE_Q60 - asq_h[60:0]};
    sn_k[0] <= {1'b0, ONE_Q60 - asq_k[60:0]};
    sr_h[0] <= '0;
    sr_k[0] <= '0;
  end

  for (genvar i = 0; i < ASQ_STEPS; i++) begin : g_asq
    localparam logic [61:0] BIT = 62'(1) << (60 - 2 * i);
    logic [61:0] th, tk;
    assign th = sr_h[i] + BIT;
    assign tk = sr_k[i] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else begin
        sv[i+1] <= sv[i];
      end
    end

    always_ff @(posedge clk) begin
      sc[i+1] <= sc[i];
      if (sn_h[i] >= th) begin
        sn_h[i+1] <= sn_h[i] - th;
        sr_h[i+1] <= (sr_h[i] >> 1) + BIT;
      end else begin
        sn_h[i+1] <= sn_h[i];
        sr_h[i+1] <= sr_h[i] >> 1;
      end
      if (sn_k[i] >= tk) begin
        sn_k[i+1] <= sn_k[i] - tk;
        sr_k[i+1] <= (sr_k[i] >> 1) + BIT;
      end else begin
        sn_k[i+1] <= sn_k[i];
        sr_k[i+1] <= sr_k[i] >> 1;
      end
    end
  end

  // three atan2 units in lockstep
  logic signed [AT_IN_W-1:0] at_y_hr, at_x_hr, s_h, s_k;
  logic                      ov_hr, ov_h, ov_k;
  logic signed [ZW-1:0]      ang_hr, ang_h, ang_k;
  acarry_t                   sl;

  always_comb begin
    sl      = sc[ASQ_STEPS];
    at_y_hr = {{(AT_IN_W-COORD_BITS){sl.r[COORD_BITS-1]}}, sl.r};
    at_x_hr = {{(AT_IN_W-COORD_BITS){sl.h[COORD_BITS-1]}}, sl.h};
    s_h     = sr_h[ASQ_STEPS][31:0];
    s_k     = sr_k[ASQ_STEPS][31:0];
  end

  tlik_atan2 u_atan_reach (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sv[ASQ_STEPS]),
    .y         (at_y_hr),
    .x         (at_x_hr),
    .out_valid (ov_hr),
    .angle     (ang_hr)
  );

  tlik_atan2 u_acos_hip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sv[ASQ_STEPS]),
    .y         (s_h),
    .x         (sl.a_h),
    .out_valid (ov_h),
    .angle     (ang_h)
  );

  tlik_atan2 u_acos_knee (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sv[ASQ_STEPS]),
    .y         (s_k),
    .x         (sl.a_k),
    .out_valid (ov_k),
    .angle     (ang_k)
  );

  // angle combine
  logic               cv;
  logic signed [27:0] hip_q, knee_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else begin
      cv <= ov_hr && ov_h && ov_k;
    end
  end

  always_ff @(posedge clk) begin
    hip_q  <= 28'(DEG90_Q16) - (28'(ang_hr) + 28'(ang_h));
    knee_q <= 28'(ang_k);
  end

  function automatic logic signed [11:0] trunc_deg(input logic signed [27:0] v);
    logic [27:0] mag_v;
    logic [11:0] q;
    mag_v = v[27] ? 28'(-v) : 28'(v);
    q     = mag_v[27:16];
    return v[27] ? $signed(-q) : $signed(q);
  endfunction

  function automatic logic [DEG_W-1:0] sat180(input logic signed [11:0] v);
    logic [DEG_W-1:0] o;
    if (v < 0) begin
      o = '0;
    end else if (v > 12'sd180) begin
      o = 8'd180;
    end else begin
      o = v[DEG_W-1:0];
    end
    return o;
  endfunction

  logic signed [11:0] hip_w, knee_w, hip_m, knee_m;
  logic               mirror_hip;

  always_comb begin
    hip_w      = trunc_deg(hip_q);
    knee_w     = trunc_deg(knee_q);
    mirror_hip = (corner == CORNER_LB) || (corner == CORNER_RF);
    hip_m      = mirror_hip ? 12'sd180 - hip_w : hip_w;
    knee_m     = mirror_hip ? knee_w : 12'sd180 - knee_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cv;
    end
  end

  always_ff @(posedge clk) begin
    result.hip_angle  <= sat180(hip_m);
    result.knee_angle <= sat180(knee_m);
  end

endmodule

`default_nettype wire

// ----- rtl/core/tlik_atan2.sv -----
// Pipelined atan2 in Q16 degrees: special cases, quadrant fold, staged normalize,
// then 20 vectoring CORDIC stages. Depends on tlik_pkg.
`default_nettype none

module tlik_atan2 (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  input  wire logic signed [tlik_pkg::AT_IN_W-1:0] y,
  input  wire logic signed [tlik_pkg::AT_IN_W-1:0] x,
  output logic                                    out_valid,
  output logic signed [tlik_pkg::ZW-1:0]          angle
);
  import tlik_pkg::*;

  localparam int NST = ATAN_LAT;

  logic                 v   [0:NST-1];
  logic signed [XW-1:0] xs  [0:NST-1];
  logic signed [XW-1:0] ys  [0:NST-1];
  logic signed [ZW-1:0] zs  [0:NST-1];
  logic                 sp  [0:NST-1];
  logic signed [ZW-1:0] spv [0:NST-1];
  logic [MW-1:0]        ms  [0:NORM_STAGES];

  logic signed [XW-1:0] xe, ye;
  logic [AT_IN_W:0]     xa, ya;

  always_comb begin
    xe = XW'(x);
    ye = XW'(y);
    xa = x[AT_IN_W-1] ? (AT_IN_W+1)'(-xe) : (AT_IN_W+1)'(xe);
    ya = y[AT_IN_W-1] ? (AT_IN_W+1)'(-ye) : (AT_IN_W+1)'(ye);
  end

  // entry: special cases and fold x<0 by +-180
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sp[0] <= (y == '0) || (x == '0);
    if (y == '0) begin
      spv[0] <= (x < 0) ? DEG180_Q16 : '0;
    end else begin
      spv[0] <= (y > 0) ? DEG90_Q16 : -DEG90_Q16;
    end
    if (x < 0) begin
      xs[0] <= -xe;
      ys[0] <= -ye;
      zs[0] <= (y > 0) ? DEG180_Q16 : -DEG180_Q16;
    end else begin
      xs[0] <= xe;
      ys[0] <= ye;
      zs[0] <= '0;
    end
    ms[0] <= (xa > ya) ? MW'(xa) : MW'(ya);
  end

  // normalize: larger magnitude brought to at least 2^40, shifts 32,16,..,1
  for (genvar j = 1; j <= NORM_STAGES; j++) begin : g_norm
    localparam int SH = 1 << (NORM_STAGES - j);
    logic shift_en;
    // shift while the result stays below 2^41, so the end lands in [2^40, 2^41)
    assign shift_en = ms[j-1] < (MW'(1) << (NORM_TGT + 1 - SH));

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else begin
        v[j] <= v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      zs[j]  <= zs[j-1];
      sp[j]  <= sp[j-1];
      spv[j] <= spv[j-1];
      if (shift_en) begin
        ms[j] <= ms[j-1] << SH;
        xs[j] <= xs[j-1] <<< SH;
        ys[j] <= ys[j-1] <<< SH;
      end else begin
        ms[j] <= ms[j-1];
        xs[j] <= xs[j-1];
        ys[j] <= ys[j-1];
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    localparam int P = 1 + NORM_STAGES + k;
    localparam logic signed [ZW-1:0] ANG = atan_q16(k);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[P] <= 1'b0;
      end else begin
        v[P] <= v[P-1];
      end
    end

    always_ff @(posedge clk) begin
      sp[P]  <= sp[P-1];
      spv[P] <= spv[P-1];
      if (ys[P-1] > 0) begin
        xs[P] <= xs[P-1] + (ys[P-1] >>> k);
        ys[P] <= ys[P-1] - (xs[P-1] >>> k);
        zs[P] <= zs[P-1] + ANG;
      end else begin
        xs[P] <= xs[P-1] - (ys[P-1] >>> k);
        ys[P] <= ys[P-1] + (xs[P-1] >>> k);
        zs[P] <= zs[P-1] - ANG;
      end
    end
  end

  assign out_valid = v[NST-1];
  assign angle     = sp[NST-1] ? spv[NST-1] : zs[NST-1];

endmodule

`default_nettype wire

// ----- rtl/core/tlik_checker.sv -----
// Port-level checks for the two-link leg IK core, bound to the top level.
// Depends on tlik_pkg for the fixed pipeline latency.
`default_nettype none

module tlik_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            result_valid,
  input wire tlik_pkg::tlik_out_t             result,
  input wire logic                            cfg_ready
);
  import tlik_pkg::*;

  // every accepted target yields its strobe after the fixed latency
  a_start_to_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT result_valid)
    else $error("missing result strobe");

  // no strobe without a transfer at the matching earlier cycle
  a_result_has_start: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(rst, PIPE_LAT)) |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without start");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.hip_angle <= 8'd180 && result.knee_angle <= 8'd180))
    else $error("angle out of range");

  a_no_backpressure: assert property (@(posedge clk) disable iff (rst)
    (!busy && cfg_ready))
    else $error("core stalled");

endmodule

bind two_link_leg_inverse_kinematics_core tlik_checker u_tlik_checker (.*);

`default_nettype wire

// ----- sim/tb_two_link_leg_inverse_kinematics_core.sv -----
// Self-checking testbench for two_link_leg_inverse_kinematics_core: random foot targets
// under several link lengths and leg corners, checked against an integer IK predictor.
// Depends on tlik_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_two_link_leg_inverse_kinematics_core;
  import tlik_pkg::*;

  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint DEG_Q16 = 64'sd65536;
  localparam longint ATAN_STEP [20] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
  // index past the register list; writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  tlik_in_t target = '0;
  logic result_valid;
  tlik_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  two_link_leg_inverse_kinematics_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .target(target),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor copy of the registers
  longint unsigned upper_len = 2560;
  longint unsigned lower_len = 2560;
  logic [1:0] corner = CORNER_LB;

  tlik_in_t targets_pending[$];
  tlik_out_t expected_angles[$];
  int mismatches = 0;
  int gap_left = 0;
  bit burst = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // Q16 degrees, vectoring CORDIC after normalizing to >= 2^40
  function automatic longint cordic_atan2(longint y, longint x);
    longint base, z, nx, ny;
    longint unsigned m;
    int k;
    base = 0;
    z = 0;
    k = 0;
    if (y == 0) return x < 0 ? 180 * DEG_Q16 : 0;
    if (x == 0) return y > 0 ? 90 * DEG_Q16 : -90 * DEG_Q16;
    if (x < 0) begin
      base = y > 0 ? 180 * DEG_Q16 : -180 * DEG_Q16;
      x = -x;
      y = -y;
    end
    m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
    while ((m << k) < (64'd1 << 40)) k++;
    x = x <<< k;
    y = y <<< k;
    for (int i = 0; i < 20; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ATAN_STEP[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ATAN_STEP[i];
      end
      x = nx;
      y = ny;
    end
    return base + z;
  endfunction

  function automatic longint cordic_acos(longint a);
    longint unsigned rem;
    rem = (64'd1 << 60) - longint'(a * a);
    return cordic_atan2(longint'(int_sqrt(rem)), a);
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  function automatic longint sat_deg(longint v);
    return v < 0 ? 0 : (v > 180 ? 180 : v);
  endfunction

  function automatic tlik_out_t ik_angles(tlik_in_t t);
    longint h, r, u, l, sd2, num, hip_cos, knee_cos, hip, knee;
    longint unsigned d2, reach_max;
    tlik_out_t o;
    h = t.target_height;
    r = t.reach;
    u = upper_len != 0 ? longint'(upper_len) : 1;
    l = lower_len != 0 ? longint'(lower_len) : 1;
    d2 = abs64(h) * abs64(h) + abs64(r) * abs64(r);
    reach_max = longint'(u + l) * longint'(u + l);
    if (d2 >= reach_max) begin
      hip_cos = ONE_Q30;
      knee_cos = -ONE_Q30;
    end else begin
      sd2 = longint'(d2);
      num = u * u + l * l - sd2;
      knee_cos = clamp_unit((num * ONE_Q30) / (2 * u * l));
      if (d2 == 0) begin
        hip_cos = ONE_Q30;
      end else begin
        num = u * u + sd2 - l * l;
        hip_cos = clamp_unit((num * ONE_Q30) / (2 * u * longint'(int_sqrt(d2))));
      end
    end
    hip = (90 * DEG_Q16 - (cordic_atan2(r, h) + cordic_acos(hip_cos))) / DEG_Q16;
    knee = cordic_acos(knee_cos) / DEG_Q16;
    if (corner == CORNER_LB || corner == CORNER_RF) hip = 180 - hip;
    else knee = 180 - knee;
    o.hip_angle = 8'(sat_deg(hip));
    o.knee_angle = 8'(sat_deg(knee));
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    if ($urandom_range(0, 63) == 0) burst = !burst;
    if (burst) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: target transfer when start && !busy
  always @(posedge clk) begin
    logic next_start;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        expected_angles.push_back(ik_angles(target));
        void'(targets_pending.pop_front());
        next_start = 1'b0;
        gap_left = pick_gap();
      end
      if (!next_start) begin
        if (gap_left > 0) gap_left--;
        else if (targets_pending.size() > 0) begin
          next_start = 1'b1;
          target <= targets_pending[0];
        end
      end
      start <= next_start;
    end
  end

  // monitor
  always @(posedge clk) begin
    tlik_out_t want;
    if (!rst && result_valid) begin
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hip=%0d knee=%0d",
                                       result.hip_angle, result.knee_angle);
      end else begin
        want = expected_angles.pop_front();
        if (result.hip_angle !== want.hip_angle ||
            result.knee_angle !== want.knee_angle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: hip exp %0d got %0d, knee exp %0d got %0d",
                     want.hip_angle, result.hip_angle, want.knee_angle,
                     result.knee_angle);
        end
      end
    end
  end

  task automatic wait_drained();
    while (targets_pending.size() != 0 || expected_angles.size() != 0 || start)
      @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_UPPER_LEN) upper_len = 64'(val[LINK_W-1:0]);
    else if (idx == REG_LOWER_LEN) lower_len = 64'(val[LINK_W-1:0]);
    else if (idx == REG_CORNER) corner = val[1:0];
    @(posedge clk);
  endtask

  task automatic add_target(int h, int r);
    tlik_in_t t;
    t.target_height = 16'(h);
    t.reach = 16'(r);
    targets_pending.push_back(t);
  endtask

  // mostly targets within one eighth past the summed link lengths per axis, some anywhere in the coordinate range
  task automatic add_random(int n);
    int span;
    for (int i = 0; i < n; i++) begin
      span = int'(upper_len + lower_len);
      span = span + span / 8 + 1;
      if (span > 32767) span = 32767;
      if ($urandom_range(0, 9) < 7)
        add_target($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span);
      else
        add_target(int'($urandom_range(0, 65535)) - 32768,
                   int'($urandom_range(0, 65535)) - 32768);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: origin, extremes, axes, reach limit, singular poses
    add_target(0, 0);
    add_target(32767, 32767);
    add_target(-32768, -32768);
    add_target(-32768, 32767);
    add_target(32767, -32768);
    add_target(0, 32767);
    add_target(0, -32768);
    add_target(5120, 0);
    add_target(5119, 0);
    add_target(0, 5120);
    add_target(-5120, 0);
    add_target(3000, 2000);
    add_target(3000, -2000);
    add_target(-3000, 1000);
    add_target(1, 0);
    add_target(0, 1);
    add_target(-1, 0);
    add_target(0, -1);
    add_target(3620, 3620);
    add_target(100, 50);
    wait_drained();

    write_reg(REG_CORNER, 16'(CORNER_RF));
    add_random(300);
    wait_drained();

    write_reg(REG_UPPER_LEN, 16'hFFFF);
    write_reg(REG_LOWER_LEN, 16'h7FFF);
    write_reg(REG_CORNER, 16'(CORNER_RB));
    add_target(32767, 32767);
    add_target(-32768, -32768);
    add_target(0, 0);
    add_random(300);
    wait_drained();

    write_reg(REG_UPPER_LEN, 16'd1);
    write_reg(REG_LOWER_LEN, 16'd1);
    write_reg(REG_CORNER, 16'(CORNER_LF));
    add_target(1, 0);
    add_target(0, 1);
    add_target(1, 1);
    add_random(250);
    wait_drained();

    // zero length register acts as one; out-of-range index is dropped
    write_reg(REG_UPPER_LEN, 16'd0);
    write_reg(REG_LOWER_LEN, 16'd300);
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_CORNER, 16'(CORNER_LB));
    add_random(250);
    wait_drained();

    write_reg(REG_UPPER_LEN, 16'($urandom_range(1, 20000)));
    write_reg(REG_LOWER_LEN, 16'($urandom_range(1, 20000)));
    write_reg(REG_CORNER, 16'($urandom_range(0, 3)));
    add_random(450);
    wait_drained();

    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
